/* rtl/tbc_pkg.sv */
// Package for the translated block cache: widths, codes and the hash helper.
// Used by every module of the block but the RAM; depends on nothing else.
package tbc_pkg;

    localparam int SLOTS = 256;
    localparam int SLOT_W = 8;
    localparam int CNT_W = 9;
    localparam int ARENA_W = 24;
    // Stored entry: key, generation, offset, code, source, instr, target, fallthrough.
    localparam int ENTRY_W = 32 + 32 + 24 + 16 + 12 + 8 + 32 + 32;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_PUBLISH = 2'd1;
    localparam logic [1:0] FUNC_RESET = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_PRECOND = 3'd2;
    localparam logic [2:0] ST_LIMIT = 3'd3;
    localparam logic [2:0] ST_DUP = 3'd4;

    localparam logic [1:0] CFG_SLOTS = 2'd0;
    localparam logic [1:0] CFG_ARENA = 2'd1;
    localparam logic [1:0] CFG_GEN = 2'd2;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] gen;
        logic [23:0] offset;
        logic [15:0] code_len;
        logic [11:0] source_len;
        logic [7:0]  instr_count;
        logic [31:0] target;
        logic [31:0] fallthrough;
    } entry_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;
        logic hash_mul;
        logic probe_first;
        logic probe_next;
        logic write_entry;
        logic take_entry;
        logic table_reset;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic mod_done;
        logic slot_used;
        logic slot_match;
        logic probe_last;
    } dp_stat_t;

endpackage

/* rtl/tbc_ram.sv */
// Generic single-port RAM with registered read.
// Standalone; used for the entry store.
module tbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/tbc_ctrl.sv */
// Controller state machine for the translated block cache.
// Depends on tbc_pkg; drives the datapath by command struct.
module tbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [1:0]        func,
    input  logic              pre_ok,
    input  logic              out_free,
    input  tbc_pkg::dp_stat_t stat,
    output tbc_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              finish,
    output logic [2:0]        fin_status,
    output logic              fin_entry,
    output logic              fin_probe
);
    import tbc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_MOD = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] func_reg, func_next;
    logic [2:0] st_reg, st_next;
    logic ent_reg, ent_next, prb_reg, prb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg <= FUNC_LOOKUP;
            st_reg <= ST_PRECOND;
            ent_reg <= 1'b0;
            prb_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg <= func_next;
            st_reg <= st_next;
            ent_reg <= ent_next;
            prb_reg <= prb_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg;
        st_next = st_reg;
        ent_next = ent_reg;
        prb_next = prb_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_item = 1'b1;
                    func_next = func;
                    ent_next = 1'b0;
                    prb_next = 1'b0;
                    st_next = ST_PRECOND;
                    if (!pre_ok)
                    begin
                        state_next = S_DONE;
                    end
                    else if (func == FUNC_RESET)
                    begin
                        cmd.table_reset = 1'b1;
                        st_next = ST_OK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                cmd.hash_mul = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.probe_first = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.slot_used)
                begin
                    if (func_reg == FUNC_LOOKUP)
                    begin
                        st_next = ST_NOT_FOUND;
                        prb_next = 1'b1;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                        st_next = ST_OK;
                        ent_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else if (stat.slot_match)
                begin
                    if (func_reg == FUNC_LOOKUP)
                    begin
                        cmd.take_entry = 1'b1;
                        st_next = ST_OK;
                        ent_next = 1'b1;
                        prb_next = 1'b1;
                    end
                    else
                    begin
                        st_next = ST_DUP;
                    end
                    state_next = S_DONE;
                end
                else if (stat.probe_last)
                begin
                    st_next = (func_reg == FUNC_LOOKUP) ? ST_NOT_FOUND : ST_LIMIT;
                    prb_next = (func_reg == FUNC_LOOKUP);
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign finish = (state_reg == S_DONE) && out_free;
    assign fin_status = st_reg;
    assign fin_entry = ent_reg;
    assign fin_probe = prb_reg;

    a_write_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entry |-> (state_reg == S_CHECK) && (func_reg == FUNC_PUBLISH))
        else $error("entry write outside a publish check");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entry |=> (state_reg == S_DONE))
        else $error("write did not finish the operation");
    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (state_reg == S_IDLE))
        else $error("item accepted while busy");

endmodule

/* rtl/tbc_dp.sv */
// Datapath of the translated block cache: hash, serial modulo, probe pointer,
// entry RAM, used bits, generation and arena cursor. Depends on tbc_pkg, tbc_ram.
module tbc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  tbc_pkg::dp_cmd_t  cmd,
    output tbc_pkg::dp_stat_t stat,
    input  logic [8:0]        n_act,
    input  logic [23:0]       arena_size,
    input  logic              gen_wr,
    input  logic [31:0]       gen_wdata,
    input  logic [31:0]       pc_key,
    input  logic [23:0]       blk_offset,
    input  logic [15:0]       blk_code_len,
    input  logic [11:0]       blk_src_len,
    input  logic [7:0]        instruction_count,
    input  logic [31:0]       exit_target,
    input  logic [31:0]       exit_fall,
    input  logic [31:0]       new_generation,
    output logic [31:0]       cur_gen,
    output logic [23:0]       cursor,
    output logic [7:0]        slot,
    output logic [8:0]        probes,
    output tbc_pkg::entry_t   rd_entry
);
    import tbc_pkg::*;

    entry_t item_reg, item_next;
    logic [31:0] gen_reg;
    logic [23:0] cursor_reg;
    logic [31:0] hash_reg;
    logic [31:0] rem_reg;
    logic [5:0] mod_cnt_reg;
    logic mod_busy_reg;
    logic [7:0] slot_reg;
    logic [8:0] probe_reg;
    logic [SLOTS-1:0] used_reg;
    entry_t ram_q;
    logic [31:0] prod;
    logic [32:0] trial;
    logic [31:0] rem_shift;
    logic [24:0] end_sum;
    logic [24:0] end_rnd;
    logic [7:0] slot_inc;

    assign item_next = '{key: pc_key, gen: gen_reg, offset: blk_offset,
        code_len: blk_code_len, source_len: blk_src_len, instr_count: instruction_count,
        target: exit_target, fallthrough: exit_fall};

    tbc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .clk(clk),
        .we(cmd.write_entry),
        .addr(slot_reg),
        .wdata(item_reg),
        .rdata(ram_q)
    );

    assign prod = item_reg.key * HASH_MULT;

    // Restoring division, one quotient bit per cycle; only the remainder is kept.
    assign rem_shift = {rem_reg[30:0], hash_reg[31]};
    assign trial = {1'b0, rem_shift} - {24'd0, n_act};

    assign end_sum = {1'b0, item_reg.offset} + {9'd0, item_reg.code_len} + 25'd15;
    assign end_rnd = {end_sum[24:4], 4'd0};
    assign slot_inc = slot_reg + 8'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item_next;
        end
        if (cmd.hash_mul)
        begin
            hash_reg <= prod ^ {16'd0, prod[31:16]};
        end
        else if (mod_busy_reg)
        begin
            hash_reg <= {hash_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= 32'd1;
            cursor_reg <= '0;
            rem_reg <= '0;
            mod_cnt_reg <= '0;
            mod_busy_reg <= 1'b0;
            slot_reg <= '0;
            probe_reg <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (gen_wr)
            begin
                gen_reg <= gen_wdata;
            end
            if (cmd.hash_mul)
            begin
                rem_reg <= '0;
                mod_cnt_reg <= '0;
                mod_busy_reg <= 1'b1;
            end
            else if (mod_busy_reg)
            begin
                rem_reg <= trial[32] ? rem_shift : trial[31:0];
                mod_cnt_reg <= mod_cnt_reg + 6'd1;
                if (mod_cnt_reg == 6'd31)
                begin
                    mod_busy_reg <= 1'b0;
                end
            end
            if (cmd.probe_first)
            begin
                slot_reg <= rem_reg[7:0];
                probe_reg <= 9'd1;
            end
            else if (cmd.probe_next)
            begin
                slot_reg <= ({1'b0, slot_inc} == n_act || slot_inc == 8'd0 && n_act == 9'd256)
                    ? 8'd0 : slot_inc;
                probe_reg <= probe_reg + 9'd1;
            end
            if (cmd.table_reset)
            begin
                used_reg <= '0;
                gen_reg <= new_generation;
                cursor_reg <= '0;
            end
            if (cmd.write_entry)
            begin
                used_reg[slot_reg] <= 1'b1;
                cursor_reg <= (end_rnd > {1'b0, arena_size}) ? arena_size : end_rnd[23:0];
            end
        end
    end

    assign stat.mod_done = !mod_busy_reg && !cmd.hash_mul;
    assign stat.slot_used = used_reg[slot_reg];
    assign stat.slot_match = (ram_q.gen == gen_reg) && (ram_q.key == item_reg.key);
    assign stat.probe_last = (probe_reg == n_act);

    assign cur_gen = gen_reg;
    assign cursor = cursor_reg;
    assign slot = slot_reg;
    assign probes = probe_reg;
    assign rd_entry = cmd.write_entry ? item_reg : ram_q;

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_next |-> (probe_reg < n_act))
        else $error("probe ran past the slots in use");
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_first |=> ({1'b0, slot_reg} < n_act))
        else $error("start slot out of range");
    a_used_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entry |=> used_reg[$past(slot_reg)])
        else $error("written slot not marked used");

endmodule

/* rtl/translated_block_cache_core.sv */
// Translated block cache top level: config registers, output register and glue.
// Depends on tbc_pkg, tbc_ctrl, tbc_dp.
// A table reset or a rejected item goes straight from acceptance to the done state; lookup and
// publish time is set by the 32-step serial modulo and by a registered RAM read per probe.
// One item at a time. The next item is taken once the result is in the output register.
// Reset (rst_n, asynchronous) clears all used marks at once and loads generation 1.
module translated_block_cache_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[1:0], pc_key[33:2], blk_offset[57:34], blk_code_len[73:58],
    // blk_src_len[85:74], instruction_count[93:86], exit_target[125:94],
    // exit_fall[157:126], new_generation[189:158], zero fill to 192.
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], slot_index[10:3], probe_count[19:11], found_offset[43:20],
    // found_code_bytes[59:44], found_source_bytes[71:60], found_instructions[79:72],
    // found_target[111:80], found_fallthrough[143:112], cursor_out[167:144].
    output logic [167:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import tbc_pkg::*;

    logic [8:0] slots_reg;
    logic [23:0] arena_reg;
    logic [8:0] n_act;
    logic s_fire, cfg_fire;
    dp_cmd_t cmd;
    dp_stat_t stat;
    logic busy, finish, fin_entry, fin_probe;
    logic [2:0] fin_status;
    logic [31:0] cur_gen;
    logic [23:0] cursor;
    logic [7:0] slot;
    logic [8:0] probes;
    entry_t rd_entry;
    logic pre_ok;
    logic [1:0] func;
    logic m_valid_reg;
    logic [167:0] m_data_reg;
    logic [2:0] hold_status;
    logic hold_entry, hold_probe;
    logic [23:0] ent_off;
    logic [15:0] ent_code;
    logic [11:0] ent_src;
    logic [7:0] ent_ins;
    logic [31:0] ent_tgt, ent_fall;
    logic [24:0] lim_sum;
    logic lim_bad;

    assign func = s_tdata[1:0];
    assign n_act = (slots_reg > 9'd256) ? 9'd256 : slots_reg;
    assign lim_sum = {1'b0, s_tdata[57:34]} + {9'd0, s_tdata[73:58]};
    assign lim_bad = (s_tdata[57:34] != cursor) || (lim_sum > {1'b0, arena_reg});

    always_comb
    begin
        pre_ok = 1'b0;
        if (n_act != 9'd0)
        begin
            case (func)
                FUNC_LOOKUP: pre_ok = (cur_gen != 32'd0);
                FUNC_PUBLISH: pre_ok = (cur_gen != 32'd0) && (s_tdata[73:58] != 16'd0)
                    && (s_tdata[85:74] != 12'd0) && (s_tdata[93:86] != 8'd0) && !lim_bad;
                FUNC_RESET: pre_ok = (s_tdata[189:158] != 32'd0)
                    && (s_tdata[189:158] != cur_gen);
                default: pre_ok = 1'b0;
            endcase
        end
    end

    // Publish that fails the arena check answers limit instead of precondition.
    logic pub_lim;
    logic pub_lim_reg;
    assign pub_lim = (func == FUNC_PUBLISH) && (n_act != 9'd0) && (cur_gen != 32'd0)
        && (s_tdata[73:58] != 16'd0) && (s_tdata[85:74] != 12'd0)
        && (s_tdata[93:86] != 8'd0) && lim_bad;

    assign s_tready = !busy;
    assign s_fire = s_tvalid && s_tready;
    assign cfg_ready = !busy;
    assign cfg_fire = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= 9'd256;
            arena_reg <= 24'hFFFFFF;
            pub_lim_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                pub_lim_reg <= pub_lim;
            end
            if (cfg_fire && cfg_index == CFG_SLOTS)
            begin
                slots_reg <= cfg_data[8:0];
            end
            if (cfg_fire && cfg_index == CFG_ARENA)
            begin
                arena_reg <= cfg_data[23:0];
            end
        end
    end

    tbc_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_fire(s_fire),
        .func(func),
        .pre_ok(pre_ok),
        .out_free(!m_valid_reg || m_tready),
        .stat(stat),
        .cmd(cmd),
        .busy(busy),
        .finish(finish),
        .fin_status(fin_status),
        .fin_entry(fin_entry),
        .fin_probe(fin_probe)
    );

    tbc_dp u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .stat(stat),
        .n_act(n_act),
        .arena_size(arena_reg),
        .gen_wr(cfg_fire && cfg_index == CFG_GEN),
        .gen_wdata(cfg_data),
        .pc_key(s_tdata[33:2]),
        .blk_offset(s_tdata[57:34]),
        .blk_code_len(s_tdata[73:58]),
        .blk_src_len(s_tdata[85:74]),
        .instruction_count(s_tdata[93:86]),
        .exit_target(s_tdata[125:94]),
        .exit_fall(s_tdata[157:126]),
        .new_generation(s_tdata[189:158]),
        .cur_gen(cur_gen),
        .cursor(cursor),
        .slot(slot),
        .probes(probes),
        .rd_entry(rd_entry)
    );

    // Entry fields are captured the cycle the check decides.
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry || cmd.take_entry)
        begin
            ent_off <= rd_entry.offset;
            ent_code <= rd_entry.code_len;
            ent_src <= rd_entry.source_len;
            ent_ins <= rd_entry.instr_count;
            ent_tgt <= rd_entry.target;
            ent_fall <= rd_entry.fallthrough;
        end
    end

    assign hold_status = pub_lim_reg ? ST_LIMIT : fin_status;
    assign hold_entry = fin_entry && !pub_lim_reg;
    assign hold_probe = fin_probe && !pub_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            m_data_reg <= {cursor,
                hold_entry ? ent_fall : 32'd0,
                hold_entry ? ent_tgt : 32'd0,
                hold_entry ? ent_ins : 8'd0,
                hold_entry ? ent_src : 12'd0,
                hold_entry ? ent_code : 16'd0,
                hold_entry ? ent_off : 24'd0,
                hold_probe ? probes : 9'd0,
                hold_entry ? slot : 8'd0,
                hold_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> !m_valid_reg || m_tready)
        else $error("result overwrote a pending transfer");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> busy)
        else $error("accepted item did not start work");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |-> !busy)
        else $error("configuration written while busy");

endmodule

/* tb/translated_block_cache_checker.sv */
`timescale 1ns / 1ps
// Checker for the translated block cache: watches the item, result and register channels,
// predicts every result from its own table model and compares. Depends on tbc_pkg.
module translated_block_cache_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending_results
);
    import tbc_pkg::*;

    logic [167:0] result_queue[$];
    logic         used_mark[SLOTS];
    entry_t       slot_store[SLOTS];
    logic [8:0]   slots_cfg;
    logic [23:0]  arena_cfg;
    logic [31:0]  live_gen;
    logic [23:0]  cursor;

    assign pending_results = result_queue.size();

    function automatic logic [31:0] home_slot(logic [31:0] pc, int n);
        logic [31:0] h;
        h = pc * HASH_MULT;
        h = h ^ (h >> 16);
        return h % n;
    endfunction

    function automatic logic [167:0] entry_fields(int s);
        logic [167:0] r;
        r = '0;
        r[10:3] = s[7:0];
        r[43:20] = slot_store[s].offset;
        r[59:44] = slot_store[s].code_len;
        r[71:60] = slot_store[s].source_len;
        r[79:72] = slot_store[s].instr_count;
        r[111:80] = slot_store[s].target;
        r[143:112] = slot_store[s].fallthrough;
        return r;
    endfunction

    task automatic predict_cache(input logic [191:0] d);
        logic [1:0]  fn;
        logic [31:0] pc;
        logic [23:0] off;
        logic [15:0] cb;
        logic [11:0] sb;
        logic [7:0]  ic;
        logic [31:0] ngen;
        logic [167:0] r;
        logic [24:0] end_pos;
        int n;
        int s;
        int p;
        bit free_found;
        bit dup;
        fn = d[1:0];
        pc = d[33:2];
        off = d[57:34];
        cb = d[73:58];
        sb = d[85:74];
        ic = d[93:86];
        ngen = d[189:158];
        n = (slots_cfg > SLOTS) ? SLOTS : slots_cfg;
        r = '0;
        r[2:0] = ST_PRECOND;
        if (n == 0 || fn == 2'd3) begin
        end else if (fn == FUNC_LOOKUP) begin
            if (live_gen != 0) begin
                s = home_slot(pc, n);
                r[2:0] = ST_NOT_FOUND;
                r[19:11] = 9'(n);
                for (p = 1; p <= n; p++) begin
                    if (!used_mark[s]) begin
                        r[19:11] = 9'(p);
                        break;
                    end
                    if (slot_store[s].gen == live_gen && slot_store[s].key == pc) begin
                        r = entry_fields(s);
                        r[2:0] = ST_OK;
                        r[19:11] = 9'(p);
                        break;
                    end
                    s = (s + 1) % n;
                end
            end
        end else if (fn == FUNC_PUBLISH) begin
            if (live_gen != 0 && sb != 0 && cb != 0 && ic != 0) begin
                if (off != cursor || off > arena_cfg || cb > arena_cfg - off) begin
                    r[2:0] = ST_LIMIT;
                end else begin
                    free_found = 0;
                    dup = 0;
                    s = home_slot(pc, n);
                    for (p = 0; p < n; p++) begin
                        if (!used_mark[s]) begin
                            free_found = 1;
                            break;
                        end
                        if (slot_store[s].gen == live_gen && slot_store[s].key == pc) begin
                            dup = 1;
                            break;
                        end
                        s = (s + 1) % n;
                    end
                    if (dup) begin
                        r[2:0] = ST_DUP;
                    end else if (!free_found) begin
                        r[2:0] = ST_LIMIT;
                    end else begin
                        used_mark[s] = 1;
                        slot_store[s] = '{pc, live_gen, off, cb, sb, ic, d[125:94], d[157:126]};
                        end_pos = ({1'b0, off} + cb + 25'd15) & ~25'd15;
                        if (end_pos > arena_cfg) end_pos = {1'b0, arena_cfg};
                        cursor = end_pos[23:0];
                        r = entry_fields(s);
                        r[2:0] = ST_OK;
                    end
                end
            end
        end else begin
            if (ngen != 0 && ngen != live_gen) begin
                for (int i = 0; i < SLOTS; i++) used_mark[i] = 0;
                live_gen = ngen;
                cursor = '0;
                r[2:0] = ST_OK;
            end
        end
        r[167:144] = cursor;
        result_queue.push_back(r);
    endtask

    initial begin
        fail_count = 0;
        slots_cfg = 9'd256;
        arena_cfg = 24'hFFFFFF;
        live_gen = 32'd1;
        cursor = '0;
        for (int i = 0; i < SLOTS; i++) used_mark[i] = 0;
    end

    always @(posedge clk) begin
        logic [167:0] want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SLOTS) slots_cfg = cfg_data[8:0];
                else if (cfg_index == CFG_ARENA) arena_cfg = cfg_data[23:0];
                else if (cfg_index == CFG_GEN) live_gen = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("Unexpected result %h", m_tdata);
                end else begin
                    want = result_queue.pop_front();
                    if (want !== m_tdata) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected %h, actual %h", want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) predict_cache(s_tdata);
        end
    end

endmodule

/* tb/translated_block_cache_core_test.sv */
`timescale 1ns / 1ps
// Top of the translated block cache testbench: clock, reset, item and register stimulus
// and the verdict. Depends on tbc_pkg, translated_block_cache_core and its checker.
module translated_block_cache_core_test;
    import tbc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           fail_count;
    int           pending_results;
    int           send_idle;
    int           recv_stall;
    logic [23:0]  cursor_guess;
    logic [31:0]  gen_guess;
    logic [31:0]  recent_pc[8];

    translated_block_cache_core dut (.*);
    translated_block_cache_checker checker_i (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk) if (m_tvalid && m_tready) cursor_guess <= m_tdata[167:144];

    // The valid flag stays up after a transfer until the next item or an idle cycle.
    task automatic send_item(input logic [1:0] fn, input logic [31:0] pc, input logic [23:0] off,
                             input logic [15:0] cb, input logic [11:0] sb, input logic [7:0] ic,
                             input logic [31:0] ngen);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b0, ngen, $urandom(), $urandom(), ic, sb, cb, off, pc, fn};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain_results();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        if (idx == CFG_GEN) gen_guess = val;
    endtask

    task automatic random_item();
        logic [31:0] pc;
        int k;
        k = $urandom_range(99);
        pc = ($urandom_range(3) == 0) ? $urandom() : recent_pc[$urandom_range(7)];
        if ($urandom_range(3) == 0) recent_pc[$urandom_range(7)] = $urandom();
        if (k < 40) begin
            send_item(FUNC_LOOKUP, pc, 24'($urandom()), 16'($urandom()), 12'($urandom()),
                      8'($urandom()), $urandom());
        end else if (k < 80) begin
            drain_results();
            send_item(FUNC_PUBLISH, pc,
                      ($urandom_range(9) == 0) ? 24'($urandom()) : cursor_guess,
                      ($urandom_range(4) == 0) ? 16'($urandom()) : 16'($urandom_range(300)),
                      ($urandom_range(19) == 0) ? 12'd0 : 12'($urandom()),
                      ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom()), $urandom());
        end else if (k < 86) begin
            if ($urandom_range(1)) gen_guess = gen_guess + 1;
            send_item(FUNC_RESET, pc, 24'd0, 16'd0, 12'd0, 8'd0,
                      ($urandom_range(2) == 0) ? $urandom() : gen_guess);
        end else if (k < 90) begin
            send_item(2'd3, pc, 24'($urandom()), 16'($urandom()), 12'($urandom()),
                      8'($urandom()), $urandom());
        end else begin
            send_item(FUNC_LOOKUP, $urandom(), 24'd0, 16'd0, 12'd0, 8'd0, 32'd0);
        end
    endtask

    initial begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = CFG_SLOTS;
        cfg_data = '0;
        send_idle = 0;
        recv_stall = 0;
        cursor_guess = '0;
        gen_guess = 32'd1;
        for (int i = 0; i < 8; i++) recent_pc[i] = $urandom();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        repeat (4) @(posedge clk);

        send_item(FUNC_LOOKUP, 32'h0, 0, 0, 0, 0, 0);
        send_item(FUNC_PUBLISH, 32'h0, 0, 16'hFFFF, 12'hFFF, 8'hFF, 0);
        send_item(FUNC_PUBLISH, 32'h0, 24'h10000, 16'd1, 12'd1, 8'd1, 0);
        send_item(FUNC_LOOKUP, 32'h0, 0, 0, 0, 0, 0);
        send_item(FUNC_PUBLISH, 32'hFFFFFFFF, 24'h10000, 16'd1, 12'd1, 8'd1, 0);
        send_item(FUNC_PUBLISH, 32'hFFFFFFFF, 24'h10010, 16'd1, 12'd1, 8'd1, 0);
        send_item(FUNC_PUBLISH, 32'h1, 24'h10010, 16'd0, 12'd1, 8'd1, 0);
        send_item(FUNC_PUBLISH, 32'h1, 24'h10010, 16'd1, 12'd0, 8'd1, 0);
        send_item(FUNC_PUBLISH, 32'h1, 24'h10010, 16'd1, 12'd1, 8'd0, 0);
        send_item(FUNC_PUBLISH, 32'h1, 24'hFFFFFF, 16'd1, 12'd1, 8'd1, 0);
        send_item(FUNC_LOOKUP, 32'hFFFFFFFF, 0, 0, 0, 0, 0);
        send_item(2'd3, 32'h0, 0, 0, 0, 0, 0);
        send_item(FUNC_RESET, 32'h0, 0, 0, 0, 0, 32'd0);
        send_item(FUNC_RESET, 32'h0, 0, 0, 0, 0, 32'd1);
        send_item(FUNC_RESET, 32'h0, 0, 0, 0, 0, 32'hFFFFFFFF);
        gen_guess = 32'hFFFFFFFF;
        send_item(FUNC_LOOKUP, 32'h0, 0, 0, 0, 0, 0);

        write_reg(CFG_SLOTS, 32'd2);
        for (int i = 0; i < 4; i++) send_item(FUNC_PUBLISH, i, 24'd0, 16'd1, 12'd1, 8'd1, 0);
        drain_results();
        send_item(FUNC_PUBLISH, 32'd9, cursor_guess, 16'd1, 12'd1, 8'd1, 0);
        send_item(FUNC_LOOKUP, 32'd9, 0, 0, 0, 0, 0);
        write_reg(CFG_SLOTS, 32'd0);
        send_item(FUNC_LOOKUP, 32'd0, 0, 0, 0, 0, 0);
        write_reg(CFG_SLOTS, 32'd511);
        write_reg(CFG_ARENA, 32'd0);
        send_item(FUNC_PUBLISH, 32'd5, cursor_guess, 16'd1, 12'd1, 8'd1, 0);
        write_reg(CFG_GEN, 32'd0);
        send_item(FUNC_LOOKUP, 32'd0, 0, 0, 0, 0, 0);
        send_item(FUNC_PUBLISH, 32'd0, 0, 16'd1, 12'd1, 8'd1, 0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 84; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 84; end
                default: begin send_idle = 33; recv_stall = 33; end
            endcase
            write_reg(CFG_SLOTS, (ph == 3) ? 32'd1 : (ph == 5) ? 32'd256 : $urandom_range(1, 40));
            write_reg(CFG_ARENA, (ph == 4) ? 32'd700 : (ph == 6) ? 32'd1 : 32'hFFFFFF);
            write_reg(CFG_GEN, (ph == 7) ? 32'hFFFFFFFF : $urandom_range(1, 1000));
            drain_results();
            for (int i = 0; i < 142; i++) random_item();
        end

        drain_results();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
